### hdl/lobs_pkg.sv
// shared constants, codes and types for the least occupied bank selector
`default_nettype none

package lobs_pkg;

   // sizes
   localparam int NUM_BANKS  = 4;
   localparam int MASK_W     = 4;
   localparam int USED_BANKS = (NUM_BANKS < MASK_W) ? NUM_BANKS : MASK_W;
   localparam int IDX_W      = (USED_BANKS > 1) ? $clog2(USED_BANKS) : 1;
   localparam int USAGE_W    = 64;
   localparam int OP_W       = 2;
   localparam int COUNT_W    = 3;
   localparam int OVR_W      = 9;
   localparam int BANK_W     = 8;
   localparam int CSR_IDX_W  = 1;

   // operation codes
   localparam logic [OP_W-1:0] OP_QUERY   = 2'd0;
   localparam logic [OP_W-1:0] OP_RESERVE = 2'd1;
   localparam logic [OP_W-1:0] OP_FREE    = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BANK_COUNT    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERRIDE_BANK = 1'b1;

   // register reset values
   localparam logic [COUNT_W-1:0] BANK_COUNT_RESET = 3'd4;
   localparam logic [OVR_W-1:0]   OVERRIDE_NONE    = 9'h1FF;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_RESULT
   } state_type;

   // sequencer to datapath control
   typedef struct packed {
      logic             load_item;
      logic             step;
      logic [IDX_W-1:0] idx;
      logic             load_result;
   } lobs_ctrl_type;

endpackage

`default_nettype wire

### hdl/lobs_channels.sv
// request, response and register write channel interfaces
`default_nettype none

interface lobs_req_if
   import lobs_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic [OP_W-1:0]       operation;
   logic [MASK_W-1:0]     bank_mask;
   logic [USAGE_W-1:0]    alloc_size;

   modport source (output valid, output operation, output bank_mask, output alloc_size,
                   input ready);
   modport sink   (input valid, input operation, input bank_mask, input alloc_size,
                   output ready);
endinterface

interface lobs_rsp_if
   import lobs_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [BANK_W-1:0] chosen_bank;
   logic              empty_mask_error;

   modport source (output valid, output chosen_bank, output empty_mask_error, input ready);
   modport sink   (input valid, input chosen_bank, input empty_mask_error, output ready);
endinterface

interface lobs_csr_if
   import lobs_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] addr;
   logic [OVR_W-1:0]     wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

### hdl/least_occupied_bank_selector_unit.sv
// Least occupied bank selector. Holds a 64-bit byte usage counter for each bank (cleared
// by reset) and serves one request beat at a time: a query returns the masked bank in use
// with the smallest usage (lowest index on a tie, bank 0 with empty_mask_error set for an
// empty mask; the override register's low 8 bits win if it is not -1); reserve and free
// add or subtract alloc_size on every masked bank in use and answer bank 0. Each request
// passes through taking the beat, one step per bank through the single shared 64-bit
// adder/comparator, and loading the response register once any earlier response is
// taken. The next request is taken while a response still waits. Register writes are
// always ready: index 0 bank_count, index 1 override_bank.
`default_nettype none

module least_occupied_bank_selector_unit
   import lobs_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   lobs_req_if.sink   req_ch,
   lobs_rsp_if.source rsp_ch,
   lobs_csr_if.sink   csr_ch
);

   lobs_ctrl_type      ctl;
   logic [COUNT_W-1:0] bank_count_ff, bank_count_in;
   logic [OVR_W-1:0]   override_ff, override_in;

   // configuration registers
   assign csr_ch.ready = 1'b1;

   always_comb begin
      bank_count_in = bank_count_ff;
      override_in   = override_ff;
      if (csr_ch.valid) begin
         case (csr_ch.addr)
            CSR_BANK_COUNT:    bank_count_in = csr_ch.wdata[COUNT_W-1:0];
            CSR_OVERRIDE_BANK: override_in   = csr_ch.wdata;
            default:           bank_count_in = bank_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_count_ff <= BANK_COUNT_RESET;
         override_ff   <= OVERRIDE_NONE;
      end else begin
         bank_count_ff <= bank_count_in;
         override_ff   <= override_in;
      end
   end

   // sequencer
   lobs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .ctl       (ctl)
   );

   // counters and shared arithmetic
   lobs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .operation        (req_ch.operation),
      .bank_mask        (req_ch.bank_mask),
      .alloc_size       (req_ch.alloc_size),
      .bank_count       (bank_count_ff),
      .override_bank    (override_ff),
      .chosen_bank      (rsp_ch.chosen_bank),
      .empty_mask_error (rsp_ch.empty_mask_error)
   );

endmodule

`default_nettype wire

### hdl/lobs_ctrl.sv
// sequencer: accepts a beat, walks the banks one per cycle, hands off the result
`default_nettype none

module lobs_ctrl
   import lobs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   output      logic          rsp_valid,
   input  wire logic          rsp_ready,
   output      lobs_ctrl_type ctl
);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             last_bank;
   logic             accept;
   logic             out_free;

   assign last_bank = (idx_ff == IDX_W'(USED_BANKS - 1));
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (last_bank) state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready       = 1'b0;
      ctl.load_item   = 1'b0;
      ctl.step        = 1'b0;
      ctl.load_result = 1'b0;
      ctl.idx         = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            ctl.load_item = req_valid;
         end
         ST_WALK: begin
            ctl.step = 1'b1;
         end
         ST_RESULT: begin
            ctl.load_result = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // bank index counter
   always_comb begin
      idx_in = idx_ff;
      if (accept) begin
         idx_in = '0;
      end else if (ctl.step && !last_bank) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### hdl/lobs_datapath.sv
// usage counters, shared 64-bit add/subtract/compare unit and result register
`default_nettype none

module lobs_datapath
   import lobs_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lobs_ctrl_type       ctl,
   input  wire logic [OP_W-1:0]     operation,
   input  wire logic [MASK_W-1:0]   bank_mask,
   input  wire logic [USAGE_W-1:0]  alloc_size,
   input  wire logic [COUNT_W-1:0]  bank_count,
   input  wire logic [OVR_W-1:0]    override_bank,
   output      logic [BANK_W-1:0]   chosen_bank,
   output      logic                empty_mask_error
);

   logic [OP_W-1:0]    op_ff;
   logic [MASK_W-1:0]  mask_ff;
   logic [USAGE_W-1:0] size_ff;
   logic [USAGE_W-1:0] usage_ff [USED_BANKS];
   logic               found_ff, found_in;
   logic [USAGE_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0]   chosen_ff, chosen_in;
   logic [BANK_W-1:0]  rsp_bank_ff, rsp_bank_in;
   logic               rsp_err_ff, rsp_err_in;

   logic [USAGE_W-1:0] opnd_a, opnd_b;
   logic               do_sub;
   logic [USAGE_W:0]   sum;
   logic               less;
   logic [COUNT_W-1:0] limit;
   logic               eligible;
   logic               is_query, is_update, take;
   logic               no_override;

   // item registers
   always_ff @(posedge clock) begin
      if (ctl.load_item) begin
         op_ff   <= operation;
         mask_ff <= bank_mask;
         size_ff <= alloc_size;
      end
   end

   // banks in use and eligibility of the current bank
   assign limit     = (bank_count > COUNT_W'(USED_BANKS)) ? COUNT_W'(USED_BANKS) : bank_count;
   assign eligible  = mask_ff[ctl.idx] && (COUNT_W'(ctl.idx) < limit);
   assign is_query  = (op_ff == OP_QUERY);
   assign is_update = (op_ff == OP_RESERVE) || (op_ff == OP_FREE);

   // shared unit: a + b for reserve, a - b for free and compare
   assign opnd_a = usage_ff[ctl.idx];
   assign opnd_b = is_query ? best_ff : size_ff;
   assign do_sub = (op_ff != OP_RESERVE);
   assign sum    = {1'b0, opnd_a} + {1'b0, opnd_b ^ {USAGE_W{do_sub}}}
                   + {{USAGE_W{1'b0}}, do_sub};
   assign less   = !sum[USAGE_W];

   // running minimum
   assign take = ctl.step && is_query && eligible && (!found_ff || less);

   always_comb begin
      found_in  = found_ff;
      best_in   = best_ff;
      chosen_in = chosen_ff;
      if (ctl.load_item) begin
         found_in  = 1'b0;
         chosen_in = '0;
      end else if (take) begin
         found_in  = 1'b1;
         best_in   = opnd_a;
         chosen_in = ctl.idx;
      end
   end

   always_ff @(posedge clock) begin
      found_ff  <= found_in;
      best_ff   <= best_in;
      chosen_ff <= chosen_in;
   end

   // usage counters
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < USED_BANKS; i++) begin
            usage_ff[i] <= '0;
         end
      end else if (ctl.step && is_update && eligible) begin
         usage_ff[ctl.idx] <= sum[USAGE_W-1:0];
      end
   end

   // result formatting
   assign no_override = (override_bank == OVERRIDE_NONE);

   always_comb begin
      rsp_bank_in = rsp_bank_ff;
      rsp_err_in  = rsp_err_ff;
      if (ctl.load_result) begin
         rsp_bank_in = '0;
         rsp_err_in  = 1'b0;
         if (is_query) begin
            if (!no_override) begin
               rsp_bank_in = override_bank[BANK_W-1:0];
            end else if (mask_ff == '0) begin
               rsp_err_in = 1'b1;
            end else begin
               rsp_bank_in = BANK_W'(chosen_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_bank_ff <= rsp_bank_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign chosen_bank      = rsp_bank_ff;
   assign empty_mask_error = rsp_err_ff;

endmodule

`default_nettype wire
